FILE: src/ubds_pkg.sv
package ubds_pkg;

    localparam int CLK_W            = 30;
    localparam int BAUD_W           = 27;
    localparam int REQ_W            = 32;
    localparam int RATE_W           = 27;
    localparam int OSR_W            = 5;
    localparam int OSR_FIRST        = 8;
    localparam int OSR_LAST         = 30;
    localparam int OSR_STEP         = 2;
    localparam int N_OSR            = (OSR_LAST - OSR_FIRST) / OSR_STEP + 1;
    localparam int DIVISOR_BITS_DEF = 16;

    localparam logic [CLK_W-1:0]  SRC_CLOCK_RESET = CLK_W'(90000000);
    localparam logic [BAUD_W-1:0] MAX_BAUD_RESET  = BAUD_W'(9000000);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_CLOCK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BAUD  = 1'b1;

    // request context that rides along the pipeline
    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [BAUD_W-1:0] baud;
        logic              skip;
    } t_shared;

    // running best candidate
    typedef struct packed {
        logic              found;
        logic [RATE_W-1:0] best;
        logic [RATE_W-1:0] err;
    } t_pick;

endpackage

FILE: src/uart_baud_divisor_search.sv
// Channel   Direction  Handshake             Payload
// request   in         i_valid / o_stall     i_requested_baud
// result    out        o_valid / i_stall     o_applied_baud, o_adjusted
// config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// One item enters per cycle unless o_stall is high; each item passes
// CLK_W + RATE_W + N_OSR + 5 = 30 + 27 + 12 + 5 = 74 register stages. The length is set
// by the two restoring divider chains (clock/baud, clock/(divisor*factor)), the
// twelve-cell selection chain and five single stages: clamp, rounding add, reciprocal
// multiply, divisor scale, output.
// Reset is synchronous, active low: it clears the valid line and loads the
// register defaults. A stall at the output freezes every stage at once.
module uart_baud_divisor_search #(
    parameter int DIVISOR_BITS = ubds_pkg::DIVISOR_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [ubds_pkg::REQ_W-1:0]       i_requested_baud,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [ubds_pkg::BAUD_W-1:0]      o_applied_baud,
    output logic                             o_adjusted,
    input  logic                             i_cfg_we,
    input  logic [ubds_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ubds_pkg::CLK_W-1:0]       i_cfg_data
);
    import ubds_pkg::*;

    localparam int X_W    = CLK_W + 1;
    localparam int XL_W   = X_W + 1;
    localparam int Y_W    = X_W - 1;
    localparam int M_W    = 32;
    localparam int P_W    = Y_W + M_W;
    localparam int D2_W   = DIVISOR_BITS + OSR_W;
    localparam int SH_W   = $bits(t_shared);
    localparam int SH_DLY = 2 + RATE_W;
    localparam int LAT    = 1 + CLK_W + 3 + RATE_W + N_OSR + 1;

    logic [CLK_W-1:0]  r_src_clock_hz;
    logic [BAUD_W-1:0] r_max_baud;
    logic              en;
    logic [LAT-1:0]    r_vld;

    // Global advance: move everything unless a finished item is held.
    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_clock_hz <= SRC_CLOCK_RESET;
            r_max_baud     <= MAX_BAUD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SRC_CLOCK: r_src_clock_hz <= i_cfg_data;
                REG_MAX_BAUD:  r_max_baud     <= i_cfg_data[BAUD_W-1:0];
            endcase
        end
    end

    // valid line across all stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Stage 0: clamp the request to the cap, mark the fallback cases.
    t_shared n_s0;
    t_shared r_s0;

    always_comb begin
        n_s0.req  = i_requested_baud;
        n_s0.baud = (i_requested_baud > REQ_W'(r_max_baud)) ? r_max_baud
                                                           : i_requested_baud[BAUD_W-1:0];
        n_s0.skip = (r_src_clock_hz == '0) || (n_s0.baud == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0 <= n_s0;
        end
    end

    // Shared divide: q0 = clock / baud. Since every factor is even,
    // round(clock / (baud*osr)) = floor((q0 + osr/2) / osr).
    logic [CLK_W-1:0] a_q0;
    logic [SH_W-1:0]  a_side;

    ubds_div #(
        .NUM_W (CLK_W),
        .DEN_W (BAUD_W),
        .QUO_W (CLK_W),
        .SIDE_W(SH_W)
    ) u_div_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_src_clock_hz),
        .i_den (r_s0.baud),
        .i_side(r_s0),
        .o_quo (a_q0),
        .o_side(a_side)
    );

    t_shared r_xsh;
    t_shared r_dly [SH_DLY];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xsh    <= t_shared'(a_side);
            r_dly[0] <= r_xsh;
            for (int i = 1; i < SH_DLY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    logic [N_OSR-1:0][RATE_W-1:0] c_rate;
    logic [N_OSR-1:0]             c_ok;

    for (genvar j = 0; j < N_OSR; j++) begin : g_osr
        localparam int OSR = OSR_FIRST + OSR_STEP * j;
        // a divisor above the limit means q0 + osr/2 >= osr * 2**DIVISOR_BITS
        localparam logic [XL_W-1:0] LIM = XL_W'(OSR) << DIVISOR_BITS;
        // floor(x / osr) = floor((x >> 1) / (osr/2)); divide by the half factor
        // with a rounded-up reciprocal, exact for every 30-bit numerator
        localparam int HALF = OSR / 2;
        localparam int SHR  = Y_W + $clog2(HALF);
        localparam logic [M_W-1:0] RECIP = M_W'(((64'd1 << SHR) / HALF) + 64'd1);

        logic [X_W-1:0]          r_x;
        logic                    r_ovf;
        logic [P_W-1:0]          prod;
        logic [DIVISOR_BITS-1:0] r_bq;
        logic                    r_bovf;
        logic [DIVISOR_BITS-1:0] div1;
        logic [D2_W-1:0]         r_d2;
        logic                    r_movf;
        logic [0:0]              c_ovf;
        logic [X_W-1:0]          x;

        assign x = X_W'(a_q0) + X_W'(OSR / 2);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_x   <= x;
                r_ovf <= XL_W'(x) >= LIM;
            end
        end

        assign prod = P_W'(r_x[X_W-1:1]) * P_W'(RECIP);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_bq   <= prod[SHR +: DIVISOR_BITS];
                r_bovf <= r_ovf;
            end
        end

        // hold the divisor at one at least, then scale by the factor
        assign div1 = (r_bq == '0) ? DIVISOR_BITS'(1) : r_bq;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d2   <= D2_W'(div1) * D2_W'(OSR);
                r_movf <= r_bovf;
            end
        end

        // achieved rate; the scaled divisor is at least 8, so 27 bits suffice
        ubds_div #(
            .NUM_W (CLK_W),
            .DEN_W (D2_W),
            .QUO_W (RATE_W),
            .SIDE_W(1)
        ) u_div_c (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_src_clock_hz),
            .i_den (r_d2),
            .i_side(r_movf),
            .o_quo (c_rate[j]),
            .o_side(c_ovf)
        );

        assign c_ok[j] = !c_ovf[0] && (c_rate[j] != '0) && (c_rate[j] <= r_max_baud);
    end

    // Selection chain: cell j weighs candidate j against the best so far.
    t_shared                      p_sh    [N_OSR+1];
    logic [N_OSR-1:0][RATE_W-1:0] p_rates [N_OSR+1];
    logic [N_OSR-1:0]             p_ok    [N_OSR+1];
    t_pick                        p_pick  [N_OSR+1];

    assign p_sh[0]    = r_dly[SH_DLY-1];
    assign p_rates[0] = c_rate;
    assign p_ok[0]    = c_ok;
    assign p_pick[0]  = '0;

    for (genvar j = 0; j < N_OSR; j++) begin : g_pick
        ubds_pick_cell #(
            .IDX(j)
        ) u_pick (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_sh   (p_sh[j]),
            .i_rates(p_rates[j]),
            .i_ok   (p_ok[j]),
            .i_pick (p_pick[j]),
            .o_sh   (p_sh[j+1]),
            .o_rates(p_rates[j+1]),
            .o_ok   (p_ok[j+1]),
            .o_pick (p_pick[j+1])
        );
    end

    // Output register: fall back to the clamped request when nothing fits.
    t_shared           f_sh;
    t_pick             f_pick;
    logic [BAUD_W-1:0] applied;
    logic [BAUD_W-1:0] r_o_applied;
    logic              r_o_adjusted;

    assign f_sh    = p_sh[N_OSR];
    assign f_pick  = p_pick[N_OSR];
    assign applied = (f_sh.skip || !f_pick.found) ? f_sh.baud : f_pick.best;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_applied  <= applied;
            r_o_adjusted <= REQ_W'(applied) != f_sh.req;
        end
    end

    assign o_applied_baud = r_o_applied;
    assign o_adjusted     = r_o_adjusted;

    // a delivered rate never exceeds the cap
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_applied_baud <= r_max_baud)
        else $error("applied baud above cap");

    // a held output freezes the whole valid line
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    // a chosen candidate is never a zero rate
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-2] && f_pick.found) |-> f_pick.best != '0)
        else $error("zero rate selected");

endmodule

FILE: src/ubds_div_cell.sv
module ubds_div_cell #(
    parameter int NUM_W  = 30,
    parameter int DEN_W  = 27,
    parameter int QUO_W  = 30,
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NUM_W-1:0]  i_rem,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [QUO_W-1:0]  i_quo,
    input  logic [SIDE_W-1:0] i_side,
    output logic [NUM_W-1:0]  o_rem,
    output logic [DEN_W-1:0]  o_den,
    output logic [QUO_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);
    localparam int W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [W-1:0]     trial;
    logic             ge;
    logic [NUM_W-1:0] n_rem;
    logic [QUO_W-1:0] n_quo;
    logic [NUM_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QUO_W-1:0] r_quo;
    logic [SIDE_W-1:0] r_side;

    // subtract the shifted divisor when it fits: one quotient bit
    always_comb begin
        trial = W'(i_den) << SHIFT;
        ge    = W'(i_rem) >= trial;
        n_rem = ge ? i_rem - trial[NUM_W-1:0] : i_rem;
        n_quo = i_quo;
        n_quo[SHIFT] = ge;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_quo  <= n_quo;
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_quo  = r_quo;
    assign o_side = r_side;
endmodule

FILE: src/ubds_div.sv
module ubds_div #(
    parameter int NUM_W  = 30,
    parameter int DEN_W  = 27,
    parameter int QUO_W  = 30,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic [QUO_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);
    // quotient valid when i_num < i_den * 2**QUO_W
    logic [QUO_W:0][NUM_W-1:0]  rem;
    logic [QUO_W:0][DEN_W-1:0]  den;
    logic [QUO_W:0][QUO_W-1:0]  quo;
    logic [QUO_W:0][SIDE_W-1:0] side;

    assign rem[0]  = i_num;
    assign den[0]  = i_den;
    assign quo[0]  = '0;
    assign side[0] = i_side;

    for (genvar s = 0; s < QUO_W; s++) begin : g_cell
        ubds_div_cell #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W),
            .QUO_W (QUO_W),
            .SHIFT (QUO_W - 1 - s),
            .SIDE_W(SIDE_W)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_rem (rem[s]),
            .i_den (den[s]),
            .i_quo (quo[s]),
            .i_side(side[s]),
            .o_rem (rem[s+1]),
            .o_den (den[s+1]),
            .o_quo (quo[s+1]),
            .o_side(side[s+1])
        );
    end

    assign o_quo  = quo[QUO_W];
    assign o_side = side[QUO_W];
endmodule

FILE: src/ubds_pick_cell.sv
module ubds_pick_cell #(
    parameter int IDX = 0
) (
    input  logic                                           i_clk,
    input  logic                                           i_en,
    input  ubds_pkg::t_shared                              i_sh,
    input  logic [ubds_pkg::N_OSR-1:0][ubds_pkg::RATE_W-1:0] i_rates,
    input  logic [ubds_pkg::N_OSR-1:0]                     i_ok,
    input  ubds_pkg::t_pick                                i_pick,
    output ubds_pkg::t_shared                              o_sh,
    output logic [ubds_pkg::N_OSR-1:0][ubds_pkg::RATE_W-1:0] o_rates,
    output logic [ubds_pkg::N_OSR-1:0]                     o_ok,
    output ubds_pkg::t_pick                                o_pick
);
    import ubds_pkg::*;

    logic [RATE_W-1:0]               rate;
    logic [RATE_W-1:0]               err;
    logic                            take;
    t_pick                           n_pick;
    t_shared                         r_sh;
    logic [N_OSR-1:0][RATE_W-1:0]    r_rates;
    logic [N_OSR-1:0]                r_ok;
    t_pick                           r_pick;

    // strict less-than keeps the smaller factor on a tie
    always_comb begin
        rate = i_rates[IDX];
        err  = (rate > i_sh.baud) ? rate - i_sh.baud : i_sh.baud - rate;
        take = i_ok[IDX] && (!i_pick.found || err < i_pick.err);
        n_pick = i_pick;
        if (take) begin
            n_pick.found = 1'b1;
            n_pick.best  = rate;
            n_pick.err   = err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh    <= i_sh;
            r_rates <= i_rates;
            r_ok    <= i_ok;
            r_pick  <= n_pick;
        end
    end

    assign o_sh    = r_sh;
    assign o_rates = r_rates;
    assign o_ok    = r_ok;
    assign o_pick  = r_pick;
endmodule
